// ===== hdl/srs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, codes and reset values of the subsystem recovery supervisor.
// ----------------------------------------------------------------------------
package srs_pkg;

	localparam int NUM_SUBSYSTEMS_DEF = 12;
	localparam int MASK_W             = 12;
	localparam int PADDR_W            = 5;

	localparam logic [1:0] EV_TICK    = 2'd0;
	localparam logic [1:0] EV_FAILURE = 2'd1;
	localparam logic [1:0] EV_HEALTHY = 2'd2;
	localparam logic [1:0] EV_DISABLE = 2'd3;

	localparam logic [2:0] H_HEALTHY    = 3'd0;
	localparam logic [2:0] H_DEGRADED   = 3'd1;
	localparam logic [2:0] H_FAILED     = 3'd2;
	localparam logic [2:0] H_RECOVERING = 3'd3;
	localparam logic [2:0] H_OFFLINE    = 3'd4;

	localparam logic [2:0] REG_MAX_ATTEMPTS   = 3'd0;
	localparam logic [2:0] REG_RETRY_COOLDOWN = 3'd1;
	localparam logic [2:0] REG_REBOOT_ENABLE  = 3'd2;
	localparam logic [2:0] REG_REBOOT_COOLDOWN = 3'd3;
	localparam logic [2:0] REG_MIN_UPTIME     = 3'd4;
	localparam logic [2:0] REG_FAILED_HOLD    = 3'd5;
	localparam logic [2:0] REG_CRITICAL_MASK  = 3'd6;

	localparam logic [3:0]        RST_MAX_ATTEMPTS    = 4'd3;
	localparam logic [31:0]       RST_RETRY_COOLDOWN  = 32'd5000;
	localparam logic              RST_REBOOT_ENABLE   = 1'b0;
	localparam logic [31:0]       RST_REBOOT_COOLDOWN = 32'd600000;
	localparam logic [31:0]       RST_MIN_UPTIME      = 32'd300000;
	localparam logic [31:0]       RST_FAILED_HOLD     = 32'd120000;
	localparam logic [MASK_W-1:0] RST_CRITICAL_MASK   = 12'd2564;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  subsystem;
		logic [31:0] now_ms;
	} evt_t;

	typedef struct packed {
		logic [2:0]  health;
		logic [3:0]  attempts;
		logic        recovery_start;
		logic        failed_now;
		logic        recovered;
		logic        reboot_request;
		logic [3:0]  reboot_cause;
		logic [31:0] recovery_total;
	} rsp_t;

	typedef struct packed {
		logic [3:0]        max_attempts;
		logic [31:0]       retry_cooldown_ms;
		logic              reboot_enable;
		logic [31:0]       reboot_cooldown_ms;
		logic [31:0]       min_uptime_ms;
		logic [31:0]       failed_hold_ms;
		logic [MASK_W-1:0] critical_mask;
	} cfg_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic        en;
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] sum;
		logic        carry;
	} alu_res_t;

endpackage

// ===== hdl/srs_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_alu
// Shared 32-bit add/subtract unit with a registered result; on subtract the
// carry is set when a >= b.
// ----------------------------------------------------------------------------
module srs_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  srs_pkg::alu_req_t   req,
	output srs_pkg::alu_res_t   res
);

	logic [31:0] b_op;
	logic [32:0] sum;

	assign b_op = (req.op == srs_pkg::ALU_SUB) ? ~req.b : req.b;
	assign sum  = {1'b0, req.a} + {1'b0, b_op} + {32'd0, (req.op == srs_pkg::ALU_SUB)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
		end else if (req.en) begin
			res.sum   <= sum[31:0];
			res.carry <= sum[32];
		end
	end

endmodule

// ===== hdl/srs_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_regs
// APB-style configuration registers of the recovery supervisor.
// ----------------------------------------------------------------------------
module srs_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output srs_pkg::cfg_t                cfg
);

	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.max_attempts       <= srs_pkg::RST_MAX_ATTEMPTS;
			cfg.retry_cooldown_ms  <= srs_pkg::RST_RETRY_COOLDOWN;
			cfg.reboot_enable      <= srs_pkg::RST_REBOOT_ENABLE;
			cfg.reboot_cooldown_ms <= srs_pkg::RST_REBOOT_COOLDOWN;
			cfg.min_uptime_ms      <= srs_pkg::RST_MIN_UPTIME;
			cfg.failed_hold_ms     <= srs_pkg::RST_FAILED_HOLD;
			cfg.critical_mask      <= srs_pkg::RST_CRITICAL_MASK;
		end else if (wr) begin
			case (idx)
				srs_pkg::REG_MAX_ATTEMPTS:    cfg.max_attempts       <= pwdata[3:0];
				srs_pkg::REG_RETRY_COOLDOWN:  cfg.retry_cooldown_ms  <= pwdata;
				srs_pkg::REG_REBOOT_ENABLE:   cfg.reboot_enable      <= pwdata[0];
				srs_pkg::REG_REBOOT_COOLDOWN: cfg.reboot_cooldown_ms <= pwdata;
				srs_pkg::REG_MIN_UPTIME:      cfg.min_uptime_ms      <= pwdata;
				srs_pkg::REG_FAILED_HOLD:     cfg.failed_hold_ms     <= pwdata;
				srs_pkg::REG_CRITICAL_MASK:
					cfg.critical_mask <= pwdata[srs_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			srs_pkg::REG_MAX_ATTEMPTS:    prdata = {28'd0, cfg.max_attempts};
			srs_pkg::REG_RETRY_COOLDOWN:  prdata = cfg.retry_cooldown_ms;
			srs_pkg::REG_REBOOT_ENABLE:   prdata = {31'd0, cfg.reboot_enable};
			srs_pkg::REG_REBOOT_COOLDOWN: prdata = cfg.reboot_cooldown_ms;
			srs_pkg::REG_MIN_UPTIME:      prdata = cfg.min_uptime_ms;
			srs_pkg::REG_FAILED_HOLD:     prdata = cfg.failed_hold_ms;
			srs_pkg::REG_CRITICAL_MASK:
				prdata = {{(32 - srs_pkg::MASK_W){1'b0}}, cfg.critical_mask};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

// ===== hdl/subsystem_recovery_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subsystem_recovery_supervisor
// Health table for a set of subsystems: failure, healthy, disable and tick
// events, retry cooldowns and last-resort reboot requests.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  evt      in         evt_valid/evt_ready  srs_pkg::evt_t
//  rsp      out        rsp_valid/rsp_ready  srs_pkg::rsp_t
//  apb      in         psel/penable/pready  paddr, pwdata, prdata
//
//  One event at a time, all time arithmetic and the recovery count through one shared add/subtract unit.
//  Out-of-range events and a tick with reboot disabled go straight to S_FIN,
//  reports and disable through their own states. A scanning tick walks N
//  entries one a cycle; a failed critical one adds S_SCAN_D and S_SCAN_C.
//  Reset clears the tables and restores register defaults; boot time is 0.
//  The next event is taken while a result waits; a stalled result holds.
// ----------------------------------------------------------------------------
module subsystem_recovery_supervisor #(
	parameter int NUM_SUBSYSTEMS = srs_pkg::NUM_SUBSYSTEMS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         evt_valid,
	output logic                         evt_ready,
	input  srs_pkg::evt_t                evt,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output srs_pkg::rsp_t                rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [srs_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int IDX_W = (NUM_SUBSYSTEMS > 1) ? $clog2(NUM_SUBSYSTEMS) : 1;
	localparam int CNT_W = $clog2(NUM_SUBSYSTEMS + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_T_CD,
		S_T_UP,
		S_T_UPCHK,
		S_SCAN,
		S_SCAN_D,
		S_SCAN_C,
		S_F_CHK,
		S_F_DEC,
		S_F_ADD,
		S_H,
		S_H_INC,
		S_DIS,
		S_FIN
	} state_t;

	state_t              state_q;
	srs_pkg::cfg_t       cfg;
	srs_pkg::alu_req_t   alu_req;
	srs_pkg::alu_res_t   alu_res;

	logic [2:0]  health_q [NUM_SUBSYSTEMS];
	logic [3:0]  attempts_q [NUM_SUBSYSTEMS];
	logic [31:0] cool_q [NUM_SUBSYSTEMS];
	logic [31:0] fsince_q [NUM_SUBSYSTEMS];
	logic [31:0] recovery_count_q;
	logic [31:0] last_reboot_q;

	logic [3:0]        sub_q;
	logic [31:0]       now_q;
	logic              sub_ok_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              rstart_q;
	logic              fnow_q;
	logic              recov_q;
	logic              rreq_q;
	logic [3:0]        rcause_q;
	logic              rsp_valid_q;
	srs_pkg::rsp_t     rsp_q;

	logic [IDX_W+3:0]      sub_ext;
	logic [CNT_W+3:0]      cnt_ext;
	logic [IDX_W-1:0]      sub_ix;
	logic [IDX_W-1:0]      rd_ix;
	logic [NUM_SUBSYSTEMS-1:0] crit_vec;
	logic [2:0]            rd_health;
	logic [3:0]            rd_attempts;
	logic [31:0]           rd_cool;
	logic [31:0]           rd_fsince;
	logic                  scan_hit;
	logic                  evt_ok;
	logic                  cnt_end;
	logic                  rsp_load;

	srs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	srs_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.res    (alu_res)
	);

	generate
		for (genvar g = 0; g < NUM_SUBSYSTEMS; g++) begin : g_crit
			if (g < srs_pkg::MASK_W) begin : g_on
				assign crit_vec[g] = cfg.critical_mask[g];
			end else begin : g_off
				assign crit_vec[g] = 1'b0;
			end
		end
	endgenerate

	assign sub_ext   = {{IDX_W{1'b0}}, sub_q};
	assign sub_ix    = sub_ext[IDX_W-1:0];
	assign cnt_ext   = {4'd0, cnt_q};
	assign cnt_end   = (cnt_q == CNT_W'(NUM_SUBSYSTEMS));
	assign rd_ix     = (state_q == S_SCAN) ? cnt_q[IDX_W-1:0] : sub_ix;
	assign rd_health   = health_q[rd_ix];
	assign rd_attempts = attempts_q[rd_ix];
	assign rd_cool     = cool_q[rd_ix];
	assign rd_fsince   = fsince_q[rd_ix];
	assign scan_hit  = crit_vec[rd_ix] && (rd_health == srs_pkg::H_FAILED) &&
	                   (rd_fsince != 32'd0);
	assign evt_ok    = (32'(evt.subsystem) < 32'(NUM_SUBSYSTEMS));
	assign rsp_load  = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);

	assign evt_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		alu_req = '0;
		alu_req.op = srs_pkg::ALU_SUB;
		case (state_q)
			S_T_CD: begin
				alu_req.en = 1'b1;
				alu_req.a  = alu_res.sum;
				alu_req.b  = cfg.reboot_cooldown_ms;
			end
			S_T_UP: begin
				alu_req.en = 1'b1;
				alu_req.a  = now_q;
				alu_req.b  = cfg.min_uptime_ms;
			end
			S_SCAN: begin
				alu_req.en = scan_hit && !cnt_end;
				alu_req.a  = now_q;
				alu_req.b  = rd_fsince;
			end
			S_SCAN_D: begin
				alu_req.en = 1'b1;
				alu_req.a  = alu_res.sum;
				alu_req.b  = cfg.failed_hold_ms;
			end
			S_F_CHK: begin
				alu_req.en = 1'b1;
				alu_req.a  = now_q;
				alu_req.b  = rd_cool;
			end
			S_F_DEC: begin
				alu_req.en = 1'b1;
				alu_req.op = srs_pkg::ALU_ADD;
				alu_req.a  = now_q;
				alu_req.b  = cfg.retry_cooldown_ms;
			end
			S_H: begin
				alu_req.en = 1'b1;
				alu_req.op = srs_pkg::ALU_ADD;
				alu_req.a  = recovery_count_q;
				alu_req.b  = 32'd1;
			end
			default: begin
				alu_req.en = 1'b0;
			end
		endcase
		if (state_q == S_IDLE) begin
			alu_req.en = evt_valid && (evt.kind == srs_pkg::EV_TICK);
			alu_req.a  = evt.now_ms;
			alu_req.b  = last_reboot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			recovery_count_q <= '0;
			last_reboot_q    <= '0;
			sub_q            <= '0;
			now_q            <= '0;
			sub_ok_q         <= 1'b0;
			cnt_q            <= '0;
			rstart_q         <= 1'b0;
			fnow_q           <= 1'b0;
			recov_q          <= 1'b0;
			rreq_q           <= 1'b0;
			rcause_q         <= '0;
			rsp_valid_q      <= 1'b0;
			rsp_q            <= '0;
			for (int i = 0; i < NUM_SUBSYSTEMS; i++) begin
				health_q[i]   <= srs_pkg::H_HEALTHY;
				attempts_q[i] <= '0;
				cool_q[i]     <= '0;
				fsince_q[i]   <= '0;
			end
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						sub_q    <= evt.subsystem;
						now_q    <= evt.now_ms;
						sub_ok_q <= evt_ok;
						cnt_q    <= '0;
						rstart_q <= 1'b0;
						fnow_q   <= 1'b0;
						recov_q  <= 1'b0;
						rreq_q   <= 1'b0;
						rcause_q <= '0;
						if (evt.kind == srs_pkg::EV_TICK) begin
							state_q <= cfg.reboot_enable ? S_T_CD : S_FIN;
						end else if (!evt_ok) begin
							state_q <= S_FIN;
						end else begin
							case (evt.kind)
								srs_pkg::EV_FAILURE: state_q <= S_F_CHK;
								srs_pkg::EV_HEALTHY: state_q <= S_H;
								default:             state_q <= S_DIS;
							endcase
						end
					end
				end
				S_T_CD: begin
					state_q <= S_T_UP;
				end
				S_T_UP: begin
					state_q <= alu_res.carry ? S_T_UPCHK : S_FIN;
				end
				S_T_UPCHK: begin
					state_q <= alu_res.carry ? S_SCAN : S_FIN;
				end
				S_SCAN: begin
					if (cnt_end) begin
						state_q <= S_FIN;
					end else if (scan_hit) begin
						state_q <= S_SCAN_D;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SCAN_D: begin
					state_q <= S_SCAN_C;
				end
				S_SCAN_C: begin
					if (alu_res.carry) begin
						rreq_q        <= 1'b1;
						rcause_q      <= cnt_ext[3:0];
						last_reboot_q <= now_q;
						state_q       <= S_FIN;
					end else begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_F_CHK: begin
					state_q <= (rd_health == srs_pkg::H_OFFLINE) ? S_FIN : S_F_DEC;
				end
				S_F_DEC: begin
					if ((rd_health != srs_pkg::H_HEALTHY) &&
					    (rd_health != srs_pkg::H_DEGRADED) && !alu_res.carry) begin
						state_q <= S_FIN;
					end else if (rd_attempts >= cfg.max_attempts) begin
						if (rd_health != srs_pkg::H_FAILED) begin
							health_q[sub_ix] <= srs_pkg::H_FAILED;
							fsince_q[sub_ix] <= now_q;
							fnow_q           <= 1'b1;
						end
						state_q <= S_FIN;
					end else begin
						health_q[sub_ix]   <= srs_pkg::H_RECOVERING;
						attempts_q[sub_ix] <= rd_attempts + 4'd1;
						rstart_q           <= 1'b1;
						state_q            <= S_F_ADD;
					end
				end
				S_F_ADD: begin
					cool_q[sub_ix] <= alu_res.sum;
					state_q        <= S_FIN;
				end
				S_H: begin
					if (rd_health == srs_pkg::H_OFFLINE) begin
						state_q <= S_FIN;
					end else begin
						health_q[sub_ix]   <= srs_pkg::H_HEALTHY;
						attempts_q[sub_ix] <= '0;
						fsince_q[sub_ix]   <= '0;
						cool_q[sub_ix]     <= '0;
						if (rd_health != srs_pkg::H_HEALTHY) begin
							recov_q <= 1'b1;
							state_q <= S_H_INC;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_H_INC: begin
					recovery_count_q <= alu_res.sum;
					state_q          <= S_FIN;
				end
				S_DIS: begin
					health_q[sub_ix] <= srs_pkg::H_OFFLINE;
					state_q          <= S_FIN;
				end
				S_FIN: begin
					if (rsp_load) begin
						rsp_q.health          <= sub_ok_q ? rd_health : srs_pkg::H_OFFLINE;
						rsp_q.attempts        <= sub_ok_q ? rd_attempts : 4'd0;
						rsp_q.recovery_start  <= rstart_q;
						rsp_q.failed_now      <= fnow_q;
						rsp_q.recovered       <= recov_q;
						rsp_q.reboot_request  <= rreq_q;
						rsp_q.reboot_cause    <= rcause_q;
						rsp_q.recovery_total  <= recovery_count_q;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the subsystem recovery supervisor. Events go in over
// a valid/ready channel with random gaps. Results come back under random
// receiver stalls, with one long hold-off that fills the block. Each result is
// checked field by field against a local model of the health table. A short
// table of directed steps runs first, some of them with hand-written results.
// After it come phases of random events, each under its own register setting
// written over APB and read back.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NSUB = srs_pkg::NUM_SUBSYSTEMS_DEF;

	typedef struct {
		logic       is_reg;
		logic [2:0] reg_idx;
		logic [31:0] reg_val;
		srs_pkg::evt_t ev;
		logic       fixed;
		srs_pkg::rsp_t want;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_ready;
	srs_pkg::evt_t evt = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	srs_pkg::rsp_t rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [srs_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	srs_pkg::cfg_t cfg_mirror;
	logic [2:0]  health_tbl[NSUB];
	logic [3:0]  attempt_tbl[NSUB];
	logic [31:0] cool_until[NSUB];
	logic [31:0] failed_at[NSUB];
	logic [31:0] recov_cnt;
	logic [31:0] last_reboot_at;

	srs_pkg::rsp_t pending_status[$];
	srs_pkg::rsp_t oldest;
	step_t       plan[$];
	int          mismatches = 0;
	int          status_seen = 0;
	logic [31:0] cyc = '0;
	logic        squeeze_on = 1'b0;
	logic        squeeze_done = 1'b0;
	logic        steady;

	subsystem_recovery_supervisor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 32'd1;
	end

	assign steady = (cyc[9:7] == 3'd0);

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic srs_pkg::rsp_t next_status(srs_pkg::evt_t e);
		srs_pkg::rsp_t r;
		logic [3:0] s;
		logic [2:0] st;
		logic [31:0] gap;
		logic hit;
		r = '0;
		s = e.subsystem;
		hit = 1'b0;
		gap = e.now_ms - last_reboot_at;
		if (e.kind == srs_pkg::EV_TICK) begin
			if (cfg_mirror.reboot_enable && gap >= cfg_mirror.reboot_cooldown_ms &&
					e.now_ms >= cfg_mirror.min_uptime_ms) begin
				for (int i = 0; i < NSUB; i++) begin
					gap = e.now_ms - failed_at[i];
					if (!hit && cfg_mirror.critical_mask[i] &&
							health_tbl[i] == srs_pkg::H_FAILED &&
							failed_at[i] != 32'd0 && gap >= cfg_mirror.failed_hold_ms) begin
						hit = 1'b1;
						last_reboot_at = e.now_ms;
						r.reboot_request = 1'b1;
						r.reboot_cause = 4'(i);
					end
				end
			end
		end else if (int'(s) < NSUB) begin
			st = health_tbl[s];
			case (e.kind)
			srs_pkg::EV_FAILURE: begin
				if (st != srs_pkg::H_OFFLINE && !(st != srs_pkg::H_HEALTHY &&
						st != srs_pkg::H_DEGRADED && e.now_ms < cool_until[s])) begin
					if (attempt_tbl[s] >= cfg_mirror.max_attempts) begin
						if (st != srs_pkg::H_FAILED) begin
							health_tbl[s] = srs_pkg::H_FAILED;
							failed_at[s] = e.now_ms;
							r.failed_now = 1'b1;
						end
					end else begin
						health_tbl[s] = srs_pkg::H_RECOVERING;
						attempt_tbl[s] = attempt_tbl[s] + 4'd1;
						cool_until[s] = e.now_ms + cfg_mirror.retry_cooldown_ms;
						r.recovery_start = 1'b1;
					end
				end
			end
			srs_pkg::EV_HEALTHY: begin
				if (st != srs_pkg::H_OFFLINE) begin
					if (st != srs_pkg::H_HEALTHY) begin
						recov_cnt = recov_cnt + 32'd1;
						r.recovered = 1'b1;
					end
					health_tbl[s] = srs_pkg::H_HEALTHY;
					attempt_tbl[s] = 4'd0;
					failed_at[s] = 32'd0;
					cool_until[s] = 32'd0;
				end
			end
			default: begin
				health_tbl[s] = srs_pkg::H_OFFLINE;
			end
			endcase
		end
		if (int'(s) < NSUB) begin
			r.health = health_tbl[s];
			r.attempts = attempt_tbl[s];
		end else begin
			r.health = srs_pkg::H_OFFLINE;
		end
		r.recovery_total = recov_cnt;
		return r;
	endfunction

	task automatic check_status(input srs_pkg::rsp_t got, input srs_pkg::rsp_t want);
		if (got.health !== want.health)
			flag_mismatch($sformatf("health got %0d want %0d", got.health, want.health));
		if (got.attempts !== want.attempts)
			flag_mismatch($sformatf("attempts got %0d want %0d", got.attempts, want.attempts));
		if (got.recovery_start !== want.recovery_start)
			flag_mismatch($sformatf("recovery_start got %0b want %0b",
				got.recovery_start, want.recovery_start));
		if (got.failed_now !== want.failed_now)
			flag_mismatch($sformatf("failed_now got %0b want %0b", got.failed_now,
				want.failed_now));
		if (got.recovered !== want.recovered)
			flag_mismatch($sformatf("recovered got %0b want %0b", got.recovered,
				want.recovered));
		if (got.reboot_request !== want.reboot_request)
			flag_mismatch($sformatf("reboot_request got %0b want %0b",
				got.reboot_request, want.reboot_request));
		if (got.reboot_cause !== want.reboot_cause)
			flag_mismatch($sformatf("reboot_cause got %0d want %0d", got.reboot_cause,
				want.reboot_cause));
		if (got.recovery_total !== want.recovery_total)
			flag_mismatch($sformatf("recovery_total got %0d want %0d",
				got.recovery_total, want.recovery_total));
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			status_seen++;
			if (pending_status.size() == 0) begin
				flag_mismatch("result transfer with nothing pending");
			end else begin
				oldest = pending_status.pop_front();
				check_status(rsp, oldest);
			end
		end
	end

	function automatic int gap_len();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (steady || squeeze_on || r < 60)
			n = 0;
		else if (r < 92)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 50);
		return n;
	endfunction

	task automatic send_evt(input srs_pkg::evt_t ev, input logic fixed,
			input srs_pkg::rsp_t want);
		srs_pkg::rsp_t guess;
		@(negedge clk);
		evt_valid <= 1'b1;
		evt <= ev;
		do @(posedge clk); while (evt_ready !== 1'b1);
		guess = next_status(ev);
		pending_status.push_back(fixed ? want : guess);
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			evt_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		evt_valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] rd;
		logic [31:0] masked;
		masked = val;
		case (idx)
		srs_pkg::REG_MAX_ATTEMPTS: begin
			masked = {28'd0, val[3:0]};
			cfg_mirror.max_attempts = val[3:0];
		end
		srs_pkg::REG_RETRY_COOLDOWN: cfg_mirror.retry_cooldown_ms = val;
		srs_pkg::REG_REBOOT_ENABLE: begin
			masked = {31'd0, val[0]};
			cfg_mirror.reboot_enable = val[0];
		end
		srs_pkg::REG_REBOOT_COOLDOWN: cfg_mirror.reboot_cooldown_ms = val;
		srs_pkg::REG_MIN_UPTIME: cfg_mirror.min_uptime_ms = val;
		srs_pkg::REG_FAILED_HOLD: cfg_mirror.failed_hold_ms = val;
		default: begin
			masked = {20'd0, val[srs_pkg::MASK_W-1:0]};
			cfg_mirror.critical_mask = val[srs_pkg::MASK_W-1:0];
		end
		endcase
		apb_xfer(1'b1, idx, val, rd);
		apb_xfer(1'b0, idx, 32'd0, rd);
		if (rd !== masked)
			flag_mismatch($sformatf("register %0d read %0h want %0h", idx, rd, masked));
	endtask

	function automatic void add_reg(input logic [2:0] idx, input logic [31:0] val);
		step_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		plan.push_back(row);
	endfunction

	function automatic void add_event(input logic [1:0] k, input logic [3:0] s,
			input logic [31:0] t);
		step_t row;
		row = '{default: '0};
		row.ev.kind = k;
		row.ev.subsystem = s;
		row.ev.now_ms = t;
		plan.push_back(row);
	endfunction

	function automatic void add_fixed(input logic [1:0] k, input logic [3:0] s,
			input logic [31:0] t, input logic [2:0] h, input logic [3:0] a, input logic rs,
			input logic fn, input logic rc, input logic [31:0] total);
		step_t row;
		row = '{default: '0};
		row.ev.kind = k;
		row.ev.subsystem = s;
		row.ev.now_ms = t;
		row.fixed = 1'b1;
		row.want.health = h;
		row.want.attempts = a;
		row.want.recovery_start = rs;
		row.want.failed_now = fn;
		row.want.recovered = rc;
		row.want.recovery_total = total;
		plan.push_back(row);
	endfunction

	// receiver: short and long stalls, one long hold-off to back the block up
	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!squeeze_done && status_seen >= 300) begin
				squeeze_on = 1'b1;
				rsp_ready <= 1'b0;
				repeat (400) @(negedge clk);
				squeeze_on = 1'b0;
				squeeze_done = 1'b1;
			end else if (stall > 0) begin
				rsp_ready <= 1'b0;
				stall--;
			end else begin
				rsp_ready <= 1'b1;
				if (!steady && $urandom_range(0, 7) == 0)
					stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
						$urandom_range(1, 3);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int r;
		int disables_left;
		logic [1:0] k;
		logic [3:0] s;
		logic [3:0] focus;
		logic [31:0] now_t;
		logic [31:0] ma, rc, en, rbc, up, hold, mask;
		srs_pkg::evt_t ev;

		cfg_mirror.max_attempts = srs_pkg::RST_MAX_ATTEMPTS;
		cfg_mirror.retry_cooldown_ms = srs_pkg::RST_RETRY_COOLDOWN;
		cfg_mirror.reboot_enable = srs_pkg::RST_REBOOT_ENABLE;
		cfg_mirror.reboot_cooldown_ms = srs_pkg::RST_REBOOT_COOLDOWN;
		cfg_mirror.min_uptime_ms = srs_pkg::RST_MIN_UPTIME;
		cfg_mirror.failed_hold_ms = srs_pkg::RST_FAILED_HOLD;
		cfg_mirror.critical_mask = srs_pkg::RST_CRITICAL_MASK;
		for (int i = 0; i < NSUB; i++) begin
			health_tbl[i] = srs_pkg::H_HEALTHY;
			attempt_tbl[i] = 4'd0;
			cool_until[i] = 32'd0;
			failed_at[i] = 32'd0;
		end
		recov_cnt = 32'd0;
		last_reboot_at = 32'd0;

		// default settings: attempt limit, retry cooldown, offline and range handling
		add_fixed(srs_pkg::EV_TICK, 4'd0, 32'd0, srs_pkg::H_HEALTHY, 4'd0,
			1'b0, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_FAILURE, 4'd15, 32'd0, srs_pkg::H_OFFLINE, 4'd0,
			1'b0, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_HEALTHY, 4'd12, 32'd100, srs_pkg::H_OFFLINE, 4'd0,
			1'b0, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_DISABLE, 4'd13, 32'd0, srs_pkg::H_OFFLINE, 4'd0,
			1'b0, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_FAILURE, 4'd2, 32'd0, srs_pkg::H_RECOVERING, 4'd1,
			1'b1, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_FAILURE, 4'd2, 32'd4999, srs_pkg::H_RECOVERING, 4'd1,
			1'b0, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_FAILURE, 4'd2, 32'd5000, srs_pkg::H_RECOVERING, 4'd2,
			1'b1, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_FAILURE, 4'd2, 32'd10000, srs_pkg::H_RECOVERING, 4'd3,
			1'b1, 1'b0, 1'b0, 32'd0);
		add_fixed(srs_pkg::EV_FAILURE, 4'd2, 32'd15000, srs_pkg::H_FAILED, 4'd3,
			1'b0, 1'b1, 1'b0, 32'd0);
		add_event(srs_pkg::EV_FAILURE, 4'd2, 32'd15001);
		add_fixed(srs_pkg::EV_HEALTHY, 4'd2, 32'd16000, srs_pkg::H_HEALTHY, 4'd0,
			1'b0, 1'b0, 1'b1, 32'd1);
		add_fixed(srs_pkg::EV_HEALTHY, 4'd2, 32'd16001, srs_pkg::H_HEALTHY, 4'd0,
			1'b0, 1'b0, 1'b0, 32'd1);
		add_fixed(srs_pkg::EV_DISABLE, 4'd5, 32'hFFFF_FFFF, srs_pkg::H_OFFLINE, 4'd0,
			1'b0, 1'b0, 1'b0, 32'd1);
		add_event(srs_pkg::EV_FAILURE, 4'd5, 32'd20000);
		add_event(srs_pkg::EV_HEALTHY, 4'd5, 32'd20001);
		add_fixed(srs_pkg::EV_FAILURE, 4'd11, 32'hFFFF_FFFF, srs_pkg::H_RECOVERING, 4'd1,
			1'b1, 1'b0, 1'b0, 32'd1);
		add_event(srs_pkg::EV_FAILURE, 4'd11, 32'hFFFF_FFFF);
		// reboot path: failed at time zero, hold time, reboot cooldown, uptime
		add_reg(srs_pkg::REG_MAX_ATTEMPTS, 32'd0);
		add_reg(srs_pkg::REG_REBOOT_ENABLE, 32'd1);
		add_reg(srs_pkg::REG_REBOOT_COOLDOWN, 32'd500);
		add_reg(srs_pkg::REG_MIN_UPTIME, 32'd1000);
		add_reg(srs_pkg::REG_FAILED_HOLD, 32'd100);
		add_reg(srs_pkg::REG_CRITICAL_MASK, 32'hFFF);
		add_event(srs_pkg::EV_FAILURE, 4'd3, 32'd0);
		add_event(srs_pkg::EV_FAILURE, 4'd7, 32'd2000);
		add_event(srs_pkg::EV_TICK, 4'd7, 32'd2050);
		add_event(srs_pkg::EV_TICK, 4'd7, 32'd2100);
		add_event(srs_pkg::EV_TICK, 4'd3, 32'd2200);
		add_event(srs_pkg::EV_TICK, 4'd0, 32'd2600);
		add_event(srs_pkg::EV_TICK, 4'd0, 32'd999);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_evt(plan[i].ev, plan[i].fixed, plan[i].want);
				idle_sender(gap_len());
			end
		end

		disables_left = 3;
		focus = 4'd0;
		now_t = 32'd3000;
		for (int p = 0; p < 8; p++) begin
			settle();
			case (p % 4)
			0: begin
				ma = 32'd0; rc = 32'd0; en = 32'd1; rbc = 32'd0;
				up = 32'd0; hold = 32'd0; mask = 32'hFFF;
			end
			1: begin
				ma = 32'd15; rc = 32'hFFFF_FFFF; en = 32'd0; rbc = 32'hFFFF_FFFF;
				up = 32'hFFFF_FFFF; hold = 32'hFFFF_FFFF; mask = 32'd0;
			end
			default: begin
				ma = ($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 4);
				rc = $urandom_range(0, 3000);
				en = ($urandom & 32'hFFFF_FFFE) | {31'd0, ($urandom_range(0, 3) != 0)};
				rbc = $urandom_range(0, 5000);
				up = $urandom_range(0, 20000);
				hold = $urandom_range(0, 3000);
				mask = $urandom;
			end
			endcase
			write_reg(srs_pkg::REG_MAX_ATTEMPTS, ma);
			write_reg(srs_pkg::REG_RETRY_COOLDOWN, rc);
			write_reg(srs_pkg::REG_REBOOT_ENABLE, en);
			write_reg(srs_pkg::REG_REBOOT_COOLDOWN, rbc);
			write_reg(srs_pkg::REG_MIN_UPTIME, up);
			write_reg(srs_pkg::REG_FAILED_HOLD, hold);
			write_reg(srs_pkg::REG_CRITICAL_MASK, mask);

			for (int n = 0; n < 160; n++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					k = srs_pkg::EV_FAILURE;
				else if (r < 75)
					k = srs_pkg::EV_TICK;
				else if (r < 97)
					k = srs_pkg::EV_HEALTHY;
				else
					k = srs_pkg::EV_DISABLE;
				if ($urandom_range(0, 15) == 0)
					focus = 4'($urandom_range(0, NSUB - 1));
				s = ($urandom_range(0, 3) != 0) ? focus : 4'($urandom_range(0, NSUB - 1));
				if ($urandom_range(0, 19) == 0)
					s = 4'($urandom_range(NSUB, 15));
				// keep most of the table alive: offline is only left through reset
				if (k == srs_pkg::EV_DISABLE && int'(s) < NSUB) begin
					if (disables_left > 0)
						disables_left--;
					else
						s = 4'($urandom_range(NSUB, 15));
				end
				r = $urandom_range(0, 99);
				if (r < 65)
					now_t = now_t + $urandom_range(0, 200);
				else if (r < 88)
					now_t = now_t + $urandom_range(200, 6000);
				else if (r >= 97)
					now_t = $urandom;
				ev.kind = k;
				ev.subsystem = s;
				ev.now_ms = now_t;
				send_evt(ev, 1'b0, '0);
				idle_sender(gap_len());
			end
		end

		settle();
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/srs_pkg.sv
hdl/srs_alu.sv
hdl/srs_regs.sv
hdl/subsystem_recovery_supervisor.sv
bench/tb_top.sv
